// ----- rtl/source_text_tokenizer_core_macros.svh -----
// Assertion macros for the source text tokenizer.
// Uses the clk and rst_n ports of the module that includes this header.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define STT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Check a consequent in the cycle after its antecedent.
`define STT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// ----- rtl/stt_pkg.sv -----
// Shared types and constants of the source text tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none

package stt_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int POS_WIDTH    = 32;
    localparam int PREFIX_WIDTH = 48;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef enum logic [4:0] {
        KIND_NUMBER  = 5'd0,
        KIND_IDENT   = 5'd1,
        KIND_FN      = 5'd2,
        KIND_LET     = 5'd3,
        KIND_IF      = 5'd4,
        KIND_WHILE   = 5'd5,
        KIND_RETURN  = 5'd6,
        KIND_EQ      = 5'd7,
        KIND_NE      = 5'd8,
        KIND_LE      = 5'd9,
        KIND_GE      = 5'd10,
        KIND_PLUS    = 5'd11,
        KIND_MINUS   = 5'd12,
        KIND_STAR    = 5'd13,
        KIND_SLASH   = 5'd14,
        KIND_PERCENT = 5'd15,
        KIND_ASSIGN  = 5'd16,
        KIND_LT      = 5'd17,
        KIND_GT      = 5'd18,
        KIND_LBRACE  = 5'd19,
        KIND_RBRACE  = 5'd20,
        KIND_LPAREN  = 5'd21,
        KIND_RPAREN  = 5'd22,
        KIND_COMMA   = 5'd23,
        KIND_SEMI    = 5'd24,
        KIND_END     = 5'd25,
        KIND_ERROR   = 5'd26
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_zero;
        logic       is_digit;
        logic       is_alpha;
        logic       is_space;
        logic       is_pend;
        logic       is_single;
        kind_t      single_kind;
    } cls_t;

    typedef struct packed {
        logic valid;
        cls_t cls;
    } fq_head_t;

    typedef struct packed {
        kind_t                  kind;
        logic [VALUE_WIDTH-1:0] value;
        logic [POS_WIDTH-1:0]   start;
        logic [POS_WIDTH-1:0]   length;
        logic                   last;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } rq_push_t;

    typedef struct packed {
        logic                room;
        logic [RQ_CNT_W-1:0] count;
    } rq_status_t;

endpackage

`default_nettype wire

// ----- rtl/stt_front.sv -----
// Front part of the tokenizer: classifies each byte and queues it.
// Depends on stt_pkg.
`default_nettype none

module stt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      text_byte,
    input  wire logic            push,
    output logic                 full,
    output stt_pkg::fq_head_t    head,
    input  wire logic            head_pop
);
    import stt_pkg::*;

    cls_t                cls;
    cls_t                mem_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg;
    logic [FQ_PTR_W-1:0] rd_ptr_reg;
    logic [FQ_CNT_W-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        cls           = '0;
        cls.ch        = text_byte;
        cls.is_zero   = (text_byte == CH_NUL);
        cls.is_digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        cls.is_alpha  = ((text_byte >= 8'h61) && (text_byte <= 8'h7A))
                     || ((text_byte >= 8'h41) && (text_byte <= 8'h5A))
                     || (text_byte == 8'h5F);
        cls.is_space  = (text_byte == 8'h20)
                     || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
        cls.is_pend   = (text_byte == CH_EQ) || (text_byte == CH_BANG)
                     || (text_byte == CH_LT) || (text_byte == CH_GT)
                     || (text_byte == CH_SLASH);
        cls.is_single = 1'b1;
        cls.single_kind = KIND_ERROR;
        unique case (text_byte)
            8'h2B:    cls.single_kind = KIND_PLUS;
            8'h2D:    cls.single_kind = KIND_MINUS;
            8'h2A:    cls.single_kind = KIND_STAR;
            8'h25:    cls.single_kind = KIND_PERCENT;
            8'h7B:    cls.single_kind = KIND_LBRACE;
            8'h7D:    cls.single_kind = KIND_RBRACE;
            8'h28:    cls.single_kind = KIND_LPAREN;
            8'h29:    cls.single_kind = KIND_RPAREN;
            8'h2C:    cls.single_kind = KIND_COMMA;
            8'h3B:    cls.single_kind = KIND_SEMI;
            default:  cls.is_single = 1'b0;
        endcase
    end

    assign full       = (count_reg == FQ_CNT_W'(FQ_DEPTH));
    assign do_push    = push && !full;
    assign head.valid = (count_reg != '0);
    assign head.cls   = mem_reg[rd_ptr_reg];
    assign do_pop     = head_pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FQ_CNT_W'(do_push) - FQ_CNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stt_back.sv -----
// Back part of the tokenizer: scan state, number and identifier tracking.
// Depends on stt_pkg; emits up to two results per byte.
`default_nettype none

module stt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire stt_pkg::fq_head_t   head,
    output logic                     head_pop,
    input  wire stt_pkg::rq_status_t rq_status,
    output stt_pkg::rq_push_t        rq_push
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_SIGN,
        MODE_COMMENT
    } mode_t;

    localparam logic [PREFIX_WIDTH-1:0] KW_FN     = 48'h0000_0000_666E;
    localparam logic [PREFIX_WIDTH-1:0] KW_LET    = 48'h0000_006C_6574;
    localparam logic [PREFIX_WIDTH-1:0] KW_IF     = 48'h0000_0000_6966;
    localparam logic [PREFIX_WIDTH-1:0] KW_WHILE  = 48'h0077_6869_6C65;
    localparam logic [PREFIX_WIDTH-1:0] KW_RETURN = 48'h7265_7475_726E;

    function automatic kind_t ident_kind(input logic [POS_WIDTH-1:0] len,
                                         input logic [PREFIX_WIDTH-1:0] pfx);
        kind_t k;
        k = KIND_IDENT;
        if (len == POS_WIDTH'(2) && pfx == KW_FN)
            k = KIND_FN;
        if (len == POS_WIDTH'(3) && pfx == KW_LET)
            k = KIND_LET;
        if (len == POS_WIDTH'(2) && pfx == KW_IF)
            k = KIND_IF;
        if (len == POS_WIDTH'(5) && pfx == KW_WHILE)
            k = KIND_WHILE;
        if (len == POS_WIDTH'(6) && pfx == KW_RETURN)
            k = KIND_RETURN;
        return k;
    endfunction

    function automatic kind_t lone_kind(input logic [7:0] p);
        kind_t k;
        priority if (p == CH_EQ)
            k = KIND_ASSIGN;
        else if (p == CH_LT)
            k = KIND_LT;
        else if (p == CH_GT)
            k = KIND_GT;
        else
            k = KIND_SLASH;
        return k;
    endfunction

    mode_t                   mode_reg,   mode_next;
    logic [VALUE_WIDTH-1:0]  acc_reg,    acc_next;
    logic [POS_WIDTH-1:0]    pos_reg,    pos_next;
    logic [POS_WIDTH-1:0]    start_reg,  start_next;
    logic [PREFIX_WIDTH-1:0] prefix_reg, prefix_next;
    logic [7:0]              pend_reg,   pend_next;

    logic                    take;
    cls_t                    c;
    logic [POS_WIDTH-1:0]    len;
    logic [3:0]              digit;
    logic                    done;
    logic                    restart;
    logic                    a_v;
    logic                    b_v;
    res_t                    res_a;
    res_t                    res_b;

    assign take     = head.valid && rq_status.room;
    assign head_pop = take;
    assign c        = head.cls;
    assign len      = pos_reg - start_reg;
    assign digit    = c.ch[3:0];

    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        prefix_next = prefix_reg;
        pend_next   = pend_reg;
        done        = 1'b0;
        restart     = 1'b0;
        a_v         = 1'b0;
        b_v         = 1'b0;
        res_a       = '0;
        res_b       = '0;

        unique case (mode_reg)
            MODE_NUM:
            begin
                if (c.is_digit)
                begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + VALUE_WIDTH'(digit);
                    done     = 1'b1;
                end
                else
                begin
                    a_v         = 1'b1;
                    res_a.kind  = KIND_NUMBER;
                    res_a.value = acc_reg;
                    res_a.start = start_reg;
                    mode_next   = MODE_IDLE;
                end
            end
            MODE_IDENT:
            begin
                if (c.is_alpha || c.is_digit)
                begin
                    if (len < POS_WIDTH'(6))
                    begin
                        prefix_next = {prefix_reg[PREFIX_WIDTH-9:0], c.ch};
                    end
                    done = 1'b1;
                end
                else
                begin
                    a_v          = 1'b1;
                    res_a.kind   = ident_kind(len, prefix_reg);
                    res_a.start  = start_reg;
                    res_a.length = len;
                    mode_next    = MODE_IDLE;
                end
            end
            MODE_SIGN:
            begin
                mode_next   = MODE_IDLE;
                res_a.start = start_reg;
                priority if (c.ch == CH_EQ && (pend_reg == CH_EQ || pend_reg == CH_BANG
                             || pend_reg == CH_LT || pend_reg == CH_GT))
                begin
                    a_v = 1'b1;
                    priority if (pend_reg == CH_EQ)
                        res_a.kind = KIND_EQ;
                    else if (pend_reg == CH_BANG)
                        res_a.kind = KIND_NE;
                    else if (pend_reg == CH_LT)
                        res_a.kind = KIND_LE;
                    else
                        res_a.kind = KIND_GE;
                    done = 1'b1;
                end
                else if (pend_reg == CH_SLASH && c.ch == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                    done      = 1'b1;
                end
                else if (pend_reg == CH_BANG)
                begin
                    a_v        = 1'b1;
                    res_a.kind = KIND_ERROR;
                    done       = 1'b1;
                    restart    = 1'b1;
                end
                else
                begin
                    a_v        = 1'b1;
                    res_a.kind = lone_kind(pend_reg);
                end
            end
            MODE_COMMENT:
            begin
                if (c.ch == CH_NL)
                begin
                    mode_next = MODE_IDLE;
                end
                done = !c.is_zero;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        res_b.start = pos_reg;
        if (!done)
        begin
            priority if (c.is_zero)
            begin
                b_v        = 1'b1;
                res_b.kind = KIND_END;
                restart    = 1'b1;
            end
            else if (c.is_space)
            begin
                mode_next = MODE_IDLE;
            end
            else if (c.is_digit)
            begin
                mode_next  = MODE_NUM;
                acc_next   = VALUE_WIDTH'(digit);
                start_next = pos_reg;
            end
            else if (c.is_alpha)
            begin
                mode_next   = MODE_IDENT;
                prefix_next = PREFIX_WIDTH'(c.ch);
                start_next  = pos_reg;
            end
            else if (c.is_pend)
            begin
                mode_next  = MODE_SIGN;
                pend_next  = c.ch;
                start_next = pos_reg;
            end
            else if (c.is_single)
            begin
                b_v        = 1'b1;
                res_b.kind = c.single_kind;
            end
            else
            begin
                b_v        = 1'b1;
                res_b.kind = KIND_ERROR;
                restart    = 1'b1;
            end
        end

        if (restart)
        begin
            mode_next   = MODE_IDLE;
            acc_next    = '0;
            pos_next    = '0;
            start_next  = '0;
            prefix_next = '0;
            pend_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end

        res_a.last = !b_v;
        res_b.last = 1'b1;
        rq_push    = '0;
        if (a_v)
        begin
            rq_push.first  = res_a;
            rq_push.second = res_b;
            rq_push.cnt    = b_v ? 2'd2 : 2'd1;
        end
        else
        begin
            rq_push.first = res_b;
            rq_push.cnt   = b_v ? 2'd1 : 2'd0;
        end
        if (!take)
        begin
            rq_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            prefix_reg <= '0;
            pend_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            prefix_reg <= prefix_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/stt_result_queue.sv -----
// Result queue of the tokenizer: takes up to two results a cycle, gives one.
// Depends on stt_pkg.
`default_nettype none

module stt_result_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stt_pkg::rq_push_t rq_push,
    output stt_pkg::rq_status_t   rq_status,
    output stt_pkg::res_t         head,
    output logic                  empty,
    input  wire logic             pop
);
    import stt_pkg::*;

    res_t                mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg;
    logic [RQ_PTR_W-1:0] rd_ptr_reg;
    logic [RQ_CNT_W-1:0] count_reg;
    logic [RQ_PTR_W-1:0] wr_ptr_second;
    logic                do_pop;

    assign empty           = (count_reg == '0);
    assign head            = mem_reg[rd_ptr_reg];
    assign do_pop          = pop && !empty;
    assign wr_ptr_second   = wr_ptr_reg + 1'b1;
    assign rq_status.count = count_reg;
    assign rq_status.room  = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (rq_push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= rq_push.first;
        end
        if (rq_push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= rq_push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(rq_push.cnt);
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + RQ_CNT_W'(rq_push.cnt) - RQ_CNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/source_text_tokenizer_core.sv -----
// Source text tokenizer: top level joining front, back and result queue.
// Depends on stt_pkg, stt_front, stt_back, stt_result_queue and the macro header.
//
// Usage:
//   Input channel: drive text_byte and raise push; a byte transfers at a rising
//   edge with push high and full low. A zero byte ends the text and yields the
//   end token; after end or an error the position restarts at zero.
//   Result channel: while empty is low, token_kind, number_value,
//   start_position, token_length and last_of_run show the oldest result; it
//   transfers at a rising edge with pop high. last_of_run marks the final
//   result a byte causes (a byte causes zero, one or two results).
// Throughput: one byte per cycle while the result queue has room, set by the
//   scan register update in the back part; two results of a byte take two pops.
// Path: a result caused by a transferred byte passes the front queue entry, then
//   the scan and write to the result queue, before it can be popped.
// Stall: while pop stays low the result queue (4 entries) fills, the scanner
//   stops once fewer than two entries are free, then the 4-entry byte queue
//   fills and full rises. Nothing is dropped.
// Reset: rst_n clears both queues and the scan state; position starts at zero.
`default_nettype none

`include "source_text_tokenizer_core_macros.svh"

module source_text_tokenizer_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [7:0]                       text_byte,
    input  wire logic                             push,
    output logic                                  full,
    output logic [4:0]                            token_kind,
    output logic [stt_pkg::VALUE_WIDTH-1:0]       number_value,
    output logic [stt_pkg::POS_WIDTH-1:0]         start_position,
    output logic [stt_pkg::POS_WIDTH-1:0]         token_length,
    output logic                                  last_of_run,
    output logic                                  empty,
    input  wire logic                             pop
);
    import stt_pkg::*;

    fq_head_t   fq_head;
    logic       fq_pop;
    rq_push_t   rq_push;
    rq_status_t rq_status;
    res_t       rq_head;
    logic       is_word_kind;

    stt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (text_byte),
        .push      (push),
        .full      (full),
        .head      (fq_head),
        .head_pop  (fq_pop)
    );

    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (fq_head),
        .head_pop  (fq_pop),
        .rq_status (rq_status),
        .rq_push   (rq_push)
    );

    stt_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .rq_push   (rq_push),
        .rq_status (rq_status),
        .head      (rq_head),
        .empty     (empty),
        .pop       (pop)
    );

    assign token_kind     = rq_head.kind;
    assign number_value   = rq_head.value;
    assign start_position = rq_head.start;
    assign token_length   = rq_head.length;
    assign last_of_run    = rq_head.last;

    assign is_word_kind   = (token_kind == KIND_IDENT) || (token_kind == KIND_FN)
                         || (token_kind == KIND_LET) || (token_kind == KIND_IF)
                         || (token_kind == KIND_WHILE) || (token_kind == KIND_RETURN);

    `STT_ASSERT_SAME(a_rq_no_overflow, 1'b1, rq_status.count <= RQ_CNT_W'(RQ_DEPTH))
    `STT_ASSERT_SAME(a_value_only_number, !empty && token_kind != KIND_NUMBER, number_value == '0)
    `STT_ASSERT_SAME(a_length_only_ident, !empty && token_length != '0, is_word_kind)
    `STT_ASSERT_NEXT(a_pop_needs_room, fq_pop, $past(rq_status.room))

endmodule

`default_nettype wire

// ----- dv/stt_token_checker.sv -----
`timescale 1ns / 1ps
// Token checker for the source text tokenizer: predicts the token stream from
// accepted text bytes and compares it with every result popped from the block.
// Depends on stt_pkg for the token kinds, result struct and character codes.
module stt_token_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      text_byte,
    input  logic                            push,
    input  logic                            full,
    input  logic [4:0]                      token_kind,
    input  logic [stt_pkg::VALUE_WIDTH-1:0] number_value,
    input  logic [stt_pkg::POS_WIDTH-1:0]   start_position,
    input  logic [stt_pkg::POS_WIDTH-1:0]   token_length,
    input  logic                            last_of_run,
    input  logic                            empty,
    input  logic                            pop,
    output int                              mismatches,
    output int                              pending,
    output int                              results_seen
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_SIGN,
        SCAN_COMMENT
    } scan_t;

    scan_t                    mode;
    logic [VALUE_WIDTH-1:0]   acc;
    logic [POS_WIDTH-1:0]     pos_next;
    logic [POS_WIDTH-1:0]     tok_start;
    logic [PREFIX_WIDTH-1:0]  prefix;
    logic [7:0]               pend;
    res_t                     tokens_due[$];

    function automatic res_t make_token(kind_t k, logic [VALUE_WIDTH-1:0] v,
                                        logic [POS_WIDTH-1:0] s, logic [POS_WIDTH-1:0] l);
        res_t r;
        r.kind   = k;
        r.value  = v;
        r.start  = s;
        r.length = l;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Single-byte signs; KIND_ERROR when the byte is not one of them
    function automatic kind_t sign_kind(logic [7:0] c);
        case (c)
            "+":      return KIND_PLUS;
            "-":      return KIND_MINUS;
            "*":      return KIND_STAR;
            CH_SLASH: return KIND_SLASH;
            "%":      return KIND_PERCENT;
            CH_EQ:    return KIND_ASSIGN;
            CH_LT:    return KIND_LT;
            CH_GT:    return KIND_GT;
            "{":      return KIND_LBRACE;
            "}":      return KIND_RBRACE;
            "(":      return KIND_LPAREN;
            ")":      return KIND_RPAREN;
            ",":      return KIND_COMMA;
            ";":      return KIND_SEMI;
            default:  return KIND_ERROR;
        endcase
    endfunction

    function automatic kind_t word_kind(logic [POS_WIDTH-1:0] len);
        if (len == 2 && prefix[15:0] == "fn")
            return KIND_FN;
        if (len == 3 && prefix[23:0] == "let")
            return KIND_LET;
        if (len == 2 && prefix[15:0] == "if")
            return KIND_IF;
        if (len == 5 && prefix[39:0] == "while")
            return KIND_WHILE;
        if (len == 6 && prefix == "return")
            return KIND_RETURN;
        return KIND_IDENT;
    endfunction

    task automatic clear_scan();
        mode      = SCAN_IDLE;
        acc       = '0;
        pos_next  = '0;
        tok_start = '0;
        prefix    = '0;
        pend      = '0;
    endtask

    task automatic predict_byte(input logic [7:0] c);
        res_t                 run[$];
        res_t                 r;
        logic [POS_WIDTH-1:0] pos;
        logic [POS_WIDTH-1:0] len;
        bit                   used;
        bit                   restart;
        kind_t                k;
        pos     = pos_next;
        used    = 1'b0;
        restart = 1'b0;
        case (mode)
            SCAN_NUMBER:
            begin
                if (is_digit(c))
                begin
                    acc  = acc * 32'd10 + 32'(c - CH_DIG0);
                    used = 1'b1;
                end
                else
                begin
                    run.push_back(make_token(KIND_NUMBER, acc, tok_start, '0));
                    mode = SCAN_IDLE;
                end
            end
            SCAN_WORD:
            begin
                len = pos - tok_start;
                if (is_alpha(c) || is_digit(c))
                begin
                    if (len < 6)
                        prefix = {prefix[PREFIX_WIDTH-9:0], c};
                    used = 1'b1;
                end
                else
                begin
                    run.push_back(make_token(word_kind(len), '0, tok_start, len));
                    mode = SCAN_IDLE;
                end
            end
            SCAN_SIGN:
            begin
                mode = SCAN_IDLE;
                if (c == CH_EQ && (pend == CH_EQ || pend == CH_BANG || pend == CH_LT ||
                                   pend == CH_GT))
                begin
                    case (pend)
                        CH_EQ:   k = KIND_EQ;
                        CH_BANG: k = KIND_NE;
                        CH_LT:   k = KIND_LE;
                        default: k = KIND_GE;
                    endcase
                    run.push_back(make_token(k, '0, tok_start, '0));
                    used = 1'b1;
                end
                else if (pend == CH_SLASH && c == CH_SLASH)
                begin
                    mode = SCAN_COMMENT;
                    used = 1'b1;
                end
                else if (pend == CH_BANG)
                begin
                    run.push_back(make_token(KIND_ERROR, '0, tok_start, '0));
                    used    = 1'b1;
                    restart = 1'b1;
                end
                else
                    run.push_back(make_token(sign_kind(pend), '0, tok_start, '0));
            end
            SCAN_COMMENT:
            begin
                if (c == CH_NL)
                    mode = SCAN_IDLE;
                used = (c != CH_NUL);
            end
            default:
                mode = SCAN_IDLE;
        endcase

        if (!used)
        begin
            if (c == CH_NUL)
            begin
                run.push_back(make_token(KIND_END, '0, pos, '0));
                restart = 1'b1;
            end
            else if (c == " " || (c >= 8'd9 && c <= 8'd13))
                mode = SCAN_IDLE;
            else if (is_digit(c))
            begin
                mode      = SCAN_NUMBER;
                acc       = 32'(c - CH_DIG0);
                tok_start = pos;
            end
            else if (is_alpha(c))
            begin
                mode      = SCAN_WORD;
                prefix    = 48'(c);
                tok_start = pos;
            end
            else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT || c == CH_SLASH)
            begin
                mode      = SCAN_SIGN;
                pend      = c;
                tok_start = pos;
            end
            else
            begin
                k = sign_kind(c);
                if (k != KIND_ERROR)
                    run.push_back(make_token(k, '0, pos, '0));
                else
                begin
                    run.push_back(make_token(KIND_ERROR, '0, pos, '0));
                    restart = 1'b1;
                end
            end
        end

        if (restart)
            clear_scan();
        else
            pos_next = pos + 1;

        foreach (run[i])
        begin
            r      = run[i];
            r.last = (i == run.size() - 1);
            tokens_due.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            clear_scan();
            tokens_due.delete();
            mismatches   = 0;
            results_seen = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.kind   = kind_t'(token_kind);
                got.value  = number_value;
                got.start  = start_position;
                got.length = token_length;
                got.last   = last_of_run;
                results_seen++;
                if (tokens_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected token: expected none, ", $time,
                             "actual kind %0d value %0d start %0d length %0d last %0d",
                             got.kind, got.value, got.start, got.length, got.last);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t token mismatch: ", $time,
                                 "expected kind %0d value %0d start %0d length %0d last %0d, ",
                                 want.kind, want.value, want.start, want.length, want.last,
                                 "actual kind %0d value %0d start %0d length %0d last %0d",
                                 got.kind, got.value, got.start, got.length, got.last);
                    end
                end
            end
            if (push && !full)
                predict_byte(text_byte);
        end
        pending = tokens_due.size();
    end

endmodule

// ----- dv/source_text_tokenizer_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the tokenizer testbench: clock, reset, text byte stimulus and result pops.
// Depends on stt_pkg, source_text_tokenizer_core and stt_token_checker.
module source_text_tokenizer_core_tb;
    import stt_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic [7:0]             text_byte;
    logic                   push;
    logic                   full;
    logic [4:0]             token_kind;
    logic [VALUE_WIDTH-1:0] number_value;
    logic [POS_WIDTH-1:0]   start_position;
    logic [POS_WIDTH-1:0]   token_length;
    logic                   last_of_run;
    logic                   empty;
    logic                   pop;

    int mismatches;
    int pending;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int items_sent;
    bit hold_request;

    source_text_tokenizer_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_byte      (text_byte),
        .push           (push),
        .full           (full),
        .token_kind     (token_kind),
        .number_value   (number_value),
        .start_position (start_position),
        .token_length   (token_length),
        .last_of_run    (last_of_run),
        .empty          (empty),
        .pop            (pop)
    );

    stt_token_checker u_token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_byte      (text_byte),
        .push           (push),
        .full           (full),
        .token_kind     (token_kind),
        .number_value   (number_value),
        .start_position (start_position),
        .token_length   (token_length),
        .last_of_run    (last_of_run),
        .empty          (empty),
        .pop            (pop),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("[source_text_tokenizer_core] ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Keywords first, then the signs in table order
    function automatic string pick_word(int idx);
        case (idx)
            0:       return "fn";
            1:       return "let";
            2:       return "if";
            3:       return "while";
            4:       return "return";
            5:       return "==";
            6:       return "!=";
            7:       return "<=";
            8:       return ">=";
            9:       return "+";
            10:      return "-";
            11:      return "*";
            12:      return "/";
            13:      return "%";
            14:      return "=";
            15:      return "<";
            16:      return ">";
            17:      return "{";
            18:      return "}";
            19:      return "(";
            20:      return ")";
            21:      return ",";
            default: return ";";
        endcase
    endfunction

    function automatic logic [7:0] word_char(bit first);
        int r;
        r = first ? $urandom_range(52) : $urandom_range(62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'(CH_DIG0 + r - 53);
    endfunction

    task automatic send_random_piece();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 8)
            send_text(pick_word($urandom_range(4)));
        else if (pick < 28)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            send_byte(word_char(1'b1));
            repeat (n - 1)
                send_byte(word_char(1'b0));
        end
        else if (pick < 46)
        begin
            n = ($urandom_range(5) == 0) ? $urandom_range(14, 9) : $urandom_range(6, 1);
            repeat (n)
                send_byte(8'(CH_DIG0 + $urandom_range(9)));
        end
        else if (pick < 70)
            send_text(pick_word($urandom_range(22, 5)));
        else if (pick < 76)
        begin
            send_text("//");
            repeat ($urandom_range(10))
                send_byte(8'($urandom_range(126, 32)));
            send_byte(($urandom_range(4) == 0) ? CH_NUL : CH_NL);
        end
        else if (pick < 84)
            send_byte(($urandom_range(6) == 0) ? 8'(" ") : 8'($urandom_range(13, 9)));
        else if (pick < 88)
            send_byte(CH_NUL);
        else if (pick < 95)
            send_byte(8'($urandom));
        else
        begin
            // broken pair: held sign followed by an arbitrary byte
            case ($urandom_range(2))
                0:       send_byte(CH_BANG);
                1:       send_byte(CH_LT);
                default: send_byte(CH_SLASH);
            endcase
            send_byte(8'($urandom));
        end
        if ($urandom_range(9) < 6)
            send_byte(" ");
    endtask

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (300)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else
                pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        text_byte     = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b0;
        bytes_sent    = 0;
        items_sent    = 0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // number overflow, lone bang, high byte, cut-short tokens, comment, control byte
        send_text("4294967297;");
        send_text("!a");
        send_byte(8'hFF);
        send_text("x");
        send_byte(CH_NUL);
        send_text("//c\n");
        send_text("<");
        send_byte(8'h01);
        send_text("#");
        wait_drained();

        items_sent    = 0;
        send_idle_pct = 25;
        recv_idle_pct = 63;
        hold_request  = 1'b1;
        while (items_sent < 400)
            send_random_piece();

        send_idle_pct = 63;
        recv_idle_pct = 25;
        while (items_sent < 800)
            send_random_piece();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < 1200)
            send_random_piece();

        wait_drained();
        repeat (8)
            @(negedge clk);

        $display("Sent %0d text bytes of keywords, names, numbers, signs, comments and noise;",
                 bytes_sent);
        $display("checked %0d tokens under mixed idling, a long pop stall and drain pauses.",
                 results_seen);
        if (mismatches == 0 && pending == 0)
            $display("[source_text_tokenizer_core] OK");
        else
            $display("[source_text_tokenizer_core] ERROR");
        $finish;
    end

endmodule

// ----- source_text_tokenizer_core.f -----
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_back.sv
rtl/stt_result_queue.sv
rtl/source_text_tokenizer_core.sv
dv/stt_token_checker.sv
dv/source_text_tokenizer_core_tb.sv
